// File: design/ilm_pkg.sv
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared constants, request codes and control types of the Ising lattice core.
// ----------------------------------------------------------------------------
package ilm_pkg;

  localparam int SIDE   = 16;
  localparam int SIDE_W = $clog2(SIDE);
  localparam int CELLS  = SIDE * SIDE;
  localparam int ADDR_W = 2 * SIDE_W;
  localparam int ACC_W  = $clog2(2 * CELLS) + 2;

  localparam int COUP_W   = 5;
  localparam int THR_W    = 32;
  localparam int ENERGY_W = 32;
  localparam int MAG_W    = 10;
  localparam int DELTA_W  = 8;
  localparam int EOUT_W   = 14;

  localparam logic signed [COUP_W-1:0]   COUP_RST   = -5'sd1;
  localparam logic signed [COUP_W-1:0]   COUP_MIN   = -5'sd8;
  localparam logic signed [COUP_W-1:0]   COUP_MAX   = 5'sd8;
  localparam logic signed [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-2 * CELLS);
  localparam logic signed [MAG_W-1:0]    MAG_RST    = MAG_W'(CELLS);
  localparam logic signed [ENERGY_W-1:0] EOUT_MAX   = ENERGY_W'((1 << (EOUT_W - 1)) - 1);
  localparam logic signed [ENERGY_W-1:0] EOUT_MIN   = ENERGY_W'(-(1 << (EOUT_W - 1)));

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TRIAL  = 2'd1,
    REQ_RECOMP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_COUPLING = 2'd0,
    CFG_ACC_SMALL = 2'd1,
    CFG_ACC_LARGE = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic ref_spin;
  } acc_ctl_t;

endpackage

// File: design/ising_metropolis_lattice_core.sv
// ----------------------------------------------------------------------------
// ising_metropolis_lattice_core
// Periodic 16x16 Ising lattice with Metropolis trials and running totals.
//
// Requests enter on in_valid/in_ready and results leave on out_valid/out_ready,
// one result per request. The block works on one request at a time and drops
// in_ready from acceptance until the result is loaded into the output register.
// A spin write or a trial passes from acceptance to out_valid through five
// reads of the spin memory (site and four neighbours), the registered read,
// delta calculation, decision with write-back, and result load. The next
// request is taken in the cycle after the result load at the earliest. A
// recompute adds a walk of three reads per site over all 256 sites, then
// drain and scale steps; the walk reads one spin at a time through the one
// memory read port feeding the shared accumulator.
// If the receiver stalls, a finished result waits in the output register; the
// block takes the next request and holds its result until the register frees.
// Reset (rst, synchronous) sets every spin to +1, coupling to -1, both
// thresholds to 0, energy to -512 and magnetization to 256. Users must write the
// configuration via cfg_we/cfg_index/cfg_data while idle; it is not enforced.
// ----------------------------------------------------------------------------
module ising_metropolis_lattice_core import ilm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [3:0]                x_pos,
  input  logic [3:0]                y_pos,
  input  logic                      spin_value,
  input  logic [THR_W-1:0]          rand_u,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      accepted,
  output logic signed [DELTA_W-1:0] delta_energy,
  output logic signed [EOUT_W-1:0]  total_energy_out,
  output logic signed [MAG_W-1:0]   magnetization_out,
  output logic                      site_spin,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [THR_W-1:0]          cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_CALC   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_WALK   = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_SCALE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                     state;
  req_t                       req_q;
  logic [SIDE_W-1:0]          row_q;
  logic [SIDE_W-1:0]          col_q;
  logic                       want_q;
  logic [THR_W-1:0]           rnd_q;
  logic [2:0]                 rd_cnt;
  logic                       site_s;
  logic signed [DELTA_W-1:0]  delta_q;
  logic                       big2_q;
  logic                       flip_q;
  logic [ADDR_W-1:0]          wsite;
  logic [1:0]                 wphase;
  logic [1:0]                 ph_d;
  logic                       pv_d;
  logic                       cur_s;

  logic signed [COUP_W-1:0]   coupling;
  logic [THR_W-1:0]           accept_small;
  logic [THR_W-1:0]           accept_large;
  logic signed [ENERGY_W-1:0] energy;
  logic signed [MAG_W-1:0]    magnet;

  logic [ADDR_W-1:0]          rd_addr;
  logic                       rd_spin;
  logic                       mem_wr_en;
  logic [ADDR_W-1:0]          site_addr;
  acc_ctl_t                   acc_ctl;
  logic signed [ACC_W-1:0]    acc;

  logic [SIDE_W-1:0]          wrow;
  logic [SIDE_W-1:0]          wcol;
  logic signed [ACC_W-1:0]    agree;
  logic signed [3:0]          agree4;
  logic signed [COUP_W+3:0]   prod;
  logic signed [COUP_W+4:0]   delta_w;
  logic [THR_W-1:0]           thr;
  logic                       trial_ok;
  logic                       flip;
  logic signed [COUP_W+ACC_W-1:0] bond_e;
  logic signed [COUP_W-1:0]   cfg_coup;
  logic signed [EOUT_W-1:0]   energy_sat;
  logic                       out_load;

  assign site_addr = {row_q, col_q};
  assign wrow      = wsite[ADDR_W-1:SIDE_W];
  assign wcol      = wsite[SIDE_W-1:0];
  assign in_ready  = (state == S_IDLE);
  assign mem_wr_en = (state == S_DECIDE) && flip;

  ilm_spin_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_spin (rd_spin),
    .wr_en   (mem_wr_en),
    .wr_addr (site_addr),
    .wr_spin (~site_s)
  );

  ilm_acc u_acc (
    .clk  (clk),
    .ctl  (acc_ctl),
    .spin (rd_spin),
    .acc  (acc)
  );

  always_comb begin
    rd_addr = site_addr;
    if (state == S_READ) begin
      case (rd_cnt)
        3'd1:    rd_addr = {row_q + SIDE_W'(1), col_q};
        3'd2:    rd_addr = {row_q - SIDE_W'(1), col_q};
        3'd3:    rd_addr = {row_q, col_q + SIDE_W'(1)};
        3'd4:    rd_addr = {row_q, col_q - SIDE_W'(1)};
        default: rd_addr = site_addr;
      endcase
    end else if (state == S_WALK) begin
      case (wphase)
        2'd1:    rd_addr = {wrow, wcol + SIDE_W'(1)};
        2'd2:    rd_addr = {wrow + SIDE_W'(1), wcol};
        default: rd_addr = wsite;
      endcase
    end
  end

  always_comb begin
    acc_ctl = '0;
    if (state == S_READ) begin
      acc_ctl.clr      = (rd_cnt == 3'd0);
      acc_ctl.add      = (rd_cnt >= 3'd2);
      acc_ctl.ref_spin = 1'b1;
    end else if (state == S_WALK || state == S_DRAIN) begin
      acc_ctl.clr      = (state == S_WALK) && (wsite == '0) && (wphase == 2'd0);
      acc_ctl.add      = pv_d && (ph_d != 2'd0);
      acc_ctl.ref_spin = cur_s;
    end
  end

  always_comb begin
    agree    = site_s ? acc : -acc;
    agree4   = agree[3:0];
    prod     = (COUP_W+4)'(coupling) * (COUP_W+4)'(agree4);
    delta_w  = -(COUP_W+5)'(prod) * (COUP_W+5)'(2);
    thr      = big2_q ? accept_small : accept_large;
    trial_ok = (delta_q <= 0) || (rnd_q < thr);
    flip     = (req_q == REQ_TRIAL) ? trial_ok :
               (req_q == REQ_WRITE) ? (site_s != want_q) : 1'b0;
    bond_e   = (COUP_W+ACC_W)'(coupling) * (COUP_W+ACC_W)'(acc);
    cfg_coup = cfg_data[COUP_W-1:0];
    if (energy > EOUT_MAX) begin
      energy_sat = EOUT_MAX[EOUT_W-1:0];
    end else if (energy < EOUT_MIN) begin
      energy_sat = EOUT_MIN[EOUT_W-1:0];
    end else begin
      energy_sat = energy[EOUT_W-1:0];
    end
  end

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling     <= COUP_RST;
      accept_small <= '0;
      accept_large <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COUPLING: begin
          if (cfg_coup < COUP_MIN) begin
            coupling <= COUP_MIN;
          end else if (cfg_coup > COUP_MAX) begin
            coupling <= COUP_MAX;
          end else begin
            coupling <= cfg_coup;
          end
        end
        CFG_ACC_SMALL: accept_small <= cfg_data;
        CFG_ACC_LARGE: accept_large <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      energy    <= ENERGY_RST;
      magnet    <= MAG_RST;
      out_valid <= 1'b0;
      flip_q    <= 1'b0;
      pv_d      <= 1'b0;
    end else begin
      pv_d <= (state == S_WALK);
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state  <= S_READ;
            flip_q <= 1'b0;
          end
        end
        S_READ: begin
          if (rd_cnt == 3'd5) begin
            case (req_q) inside
              REQ_WRITE, REQ_TRIAL: state <= S_CALC;
              REQ_RECOMP:           state <= S_WALK;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_CALC: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          flip_q <= flip;
          if (flip) begin
            energy <= energy + ENERGY_W'(delta_q);
            magnet <= site_s ? magnet - MAG_W'(2) : magnet + MAG_W'(2);
          end
          state <= S_DONE;
        end
        S_WALK: begin
          if (wphase == 2'd2 && wsite == ADDR_W'(CELLS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          energy <= ENERGY_W'(bond_e);
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_q  <= req_t'(req_type);
      row_q  <= x_pos[SIDE_W-1:0];
      col_q  <= y_pos[SIDE_W-1:0];
      want_q <= spin_value;
      rnd_q  <= rand_u;
      rd_cnt <= 3'd0;
    end else if (state == S_READ) begin
      rd_cnt <= rd_cnt + 3'd1;
      if (rd_cnt == 3'd1) begin
        site_s <= rd_spin;
      end
      wsite  <= '0;
      wphase <= 2'd0;
    end
    if (state == S_CALC) begin
      delta_q <= delta_w[DELTA_W-1:0];
      big2_q  <= (agree == ACC_W'(2)) || (agree == -ACC_W'(2));
    end
    if (state == S_DECIDE && flip) begin
      site_s <= ~site_s;
    end
    if (state == S_WALK) begin
      ph_d <= wphase;
      if (wphase == 2'd2) begin
        wphase <= 2'd0;
        wsite  <= wsite + ADDR_W'(1);
      end else begin
        wphase <= wphase + 2'd1;
      end
    end
    if (pv_d && ph_d == 2'd0) begin
      cur_s <= rd_spin;
    end
    if (out_load) begin
      accepted          <= flip_q && (req_q == REQ_TRIAL);
      delta_energy      <= (req_q == REQ_TRIAL) ? delta_q : '0;
      total_energy_out  <= energy_sat;
      magnetization_out <= magnet;
      site_spin         <= site_s;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ)
    else $error("accepted request did not start the read sequence");

  a_walk_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_DRAIN) |-> !mem_wr_en)
    else $error("spin memory written during energy walk");

  a_downhill_flips: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE && req_q == REQ_TRIAL && delta_q <= 0 |=> flip_q)
    else $error("non-positive energy change was rejected");

  a_flip_moves_magnet: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE && flip |=> magnet != $past(magnet))
    else $error("spin flip left magnetization unchanged");

endmodule

// File: design/ilm_spin_mem.sv
// ----------------------------------------------------------------------------
// ilm_spin_mem
// Spin store with one read port and one write port, registered read; entries never written read +1.
// ----------------------------------------------------------------------------
module ilm_spin_mem import ilm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_spin,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_spin
);

  logic             mem [CELLS];
  logic [CELLS-1:0] valid;
  logic             mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_spin;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_spin = valid_q ? mem_q : 1'b1;

endmodule

// File: design/ilm_acc.sv
// ----------------------------------------------------------------------------
// ilm_acc
// Shared plus/minus one accumulator for neighbour sums and bond sums.
// ----------------------------------------------------------------------------
module ilm_acc import ilm_pkg::*; (
  input  logic                    clk,
  input  acc_ctl_t                ctl,
  input  logic                    spin,
  output logic signed [ACC_W-1:0] acc
);

  logic up;

  assign up = spin ^ ~ctl.ref_spin;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= up ? acc + ACC_W'(1) : acc - ACC_W'(1);
    end
  end

endmodule

// File: test/ising_metropolis_lattice_core_tb.sv
// ----------------------------------------------------------------------------
// ising_metropolis_lattice_core_tb
// Self-checking bench for the Ising lattice core. A short directed opening
// covers every request type, threshold edges, lattice wraparound and coupling
// saturation. Random requests then run under several couplings and thresholds,
// with idle gaps on both sides, a long output hold-off and stale-energy phases.
// Each result is compared field by field with a running model of the lattice,
// its energy and its magnetization.
// ----------------------------------------------------------------------------
module ising_metropolis_lattice_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilm_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_TAIL   = 40;
  localparam int REPORT_LIMIT = 40;
  localparam int PHASE_ITEMS  = 180;
  localparam int STALE_ITEMS  = 100;

  typedef struct packed {
    logic                      accepted;
    logic signed [DELTA_W-1:0] delta;
    logic signed [EOUT_W-1:0]  energy;
    logic signed [MAG_W-1:0]   magnet;
    logic                      spin;
  } lattice_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                req_type;
  logic [3:0]                x_pos;
  logic [3:0]                y_pos;
  logic                      spin_value;
  logic [THR_W-1:0]          rand_u;
  logic                      out_valid;
  logic                      out_ready;
  logic                      accepted;
  logic signed [DELTA_W-1:0] delta_energy;
  logic signed [EOUT_W-1:0]  total_energy_out;
  logic signed [MAG_W-1:0]   magnetization_out;
  logic                      site_spin;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [THR_W-1:0]          cfg_data;

  logic [CELLS-1:0] lattice;
  int               lattice_energy;
  int               lattice_magnet;
  int               bond_strength;
  logic [THR_W-1:0] small_threshold;
  logic [THR_W-1:0] large_threshold;

  lattice_result_t pending_results[$];
  int              error_count = 0;
  bit              sender_pauses = 1'b0;
  bit              sink_stalls = 1'b0;
  int              hold_off_cycles = 0;

  ising_metropolis_lattice_core DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .x_pos             (x_pos),
    .y_pos             (y_pos),
    .spin_value        (spin_value),
    .rand_u            (rand_u),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .accepted          (accepted),
    .delta_energy      (delta_energy),
    .total_energy_out  (total_energy_out),
    .magnetization_out (magnetization_out),
    .site_spin         (site_spin),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int spin_of(int r, int c);
    return lattice[(r % SIDE) * SIDE + (c % SIDE)] ? 1 : -1;
  endfunction

  function automatic int neighbour_total(int r, int c);
    return spin_of(r + 1, c) + spin_of(r + SIDE - 1, c)
         + spin_of(r, c + 1) + spin_of(r, c + SIDE - 1);
  endfunction

  function automatic lattice_result_t predict_request(req_t req, logic [3:0] row,
                                                      logic [3:0] col, logic spin_in,
                                                      logic [THR_W-1:0] rnd);
    lattice_result_t res;
    int r, c, site, s, agree, delta, e, i, j;
    logic flip;
    r = int'(row) % SIDE;
    c = int'(col) % SIDE;
    site = r * SIDE + c;
    flip = 1'b0;
    delta = 0;
    case (req)
      REQ_WRITE: begin
        if (lattice[site] != spin_in) begin
          s = spin_of(r, c);
          lattice_energy += -2 * bond_strength * s * neighbour_total(r, c);
          lattice_magnet += -2 * s;
          lattice[site] = spin_in;
        end
      end
      REQ_TRIAL: begin
        s = spin_of(r, c);
        agree = s * neighbour_total(r, c);
        delta = -2 * bond_strength * agree;
        if (delta <= 0) flip = 1'b1;
        else if (agree == 2 || agree == -2) flip = rnd < small_threshold;
        else flip = rnd < large_threshold;
        if (flip) begin
          lattice[site] = ~lattice[site];
          lattice_energy += delta;
          lattice_magnet += -2 * s;
        end
      end
      REQ_RECOMP: begin
        e = 0;
        for (i = 0; i < SIDE; i++) begin
          for (j = 0; j < SIDE; j++) begin
            e += bond_strength * spin_of(i, j) * (spin_of(i + 1, j) + spin_of(i, j + 1));
          end
        end
        lattice_energy = e;
      end
      default: ;
    endcase
    res.accepted = flip;
    res.delta = DELTA_W'(clamp_int(delta, -(1 << (DELTA_W - 1)), (1 << (DELTA_W - 1)) - 1));
    res.energy = EOUT_W'(clamp_int(lattice_energy, -(1 << (EOUT_W - 1)),
                                   (1 << (EOUT_W - 1)) - 1));
    res.magnet = MAG_W'(clamp_int(lattice_magnet, -(1 << (MAG_W - 1)),
                                  (1 << (MAG_W - 1)) - 1));
    res.spin = lattice[site];
    return res;
  endfunction

  function automatic int idle_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [THR_W-1:0] random_fraction();
    logic [THR_W-1:0] cut;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: begin
        cut = $urandom_range(0, 1) ? small_threshold : large_threshold;
        return cut + THR_W'($urandom_range(0, 2)) - THR_W'(1);
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(string label, int want_v, int got_v);
    if (want_v != got_v) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
    end
  endfunction

  task automatic send_request(req_t req, logic [3:0] row, logic [3:0] col, logic spin_in,
                              logic [THR_W-1:0] rnd);
    req_type   <= req;
    x_pos      <= row;
    y_pos      <= col;
    spin_value <= spin_in;
    rand_u     <= rnd;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_request(req, row, col, spin_in, rnd));
    if (sender_pauses && $urandom_range(0, 99) < 40) begin
      in_valid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t index, logic [THR_W-1:0] value);
    logic signed [COUP_W-1:0] code;
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_COUPLING: begin
        code = value[COUP_W-1:0];
        bond_strength = clamp_int(int'(code), int'(COUP_MIN), int'(COUP_MAX));
      end
      CFG_ACC_SMALL: small_threshold = value;
      CFG_ACC_LARGE: large_threshold = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_random_request();
    int pick;
    req_t req;
    pick = $urandom_range(0, 99);
    if (pick < 30) req = REQ_WRITE;
    else if (pick < 94) req = REQ_TRIAL;
    else if (pick < 97) req = REQ_NONE;
    else req = REQ_RECOMP;
    if (pick == 50) wait_for_results();
    send_request(req, 4'($urandom()), 4'($urandom()), 1'($urandom()), random_fraction());
  endtask

  task automatic test_directed_requests();
    send_request(REQ_NONE, 0, 0, 0, '0);
    send_request(REQ_RECOMP, 15, 15, 1, '1);
    send_request(REQ_TRIAL, 3, 4, 1, '0);
    send_request(REQ_WRITE, 0, 0, 0, '1);
    send_request(REQ_WRITE, 15, 15, 0, '0);
    send_request(REQ_WRITE, 0, 15, 0, '0);
    send_request(REQ_WRITE, 7, 7, 1, '0);
    send_request(REQ_TRIAL, 15, 0, 1, '0);
    send_request(REQ_NONE, 15, 15, 1, '1);
    wait_for_results();
    write_register(CFG_ACC_SMALL, '1);
    write_register(CFG_ACC_LARGE, 32'd1);
    send_request(REQ_TRIAL, 8, 8, 0, '0);
    send_request(REQ_TRIAL, 8, 8, 0, '1);
    send_request(REQ_WRITE, 9, 9, 0, '0);
    send_request(REQ_TRIAL, 10, 9, 1, '1);
    send_request(REQ_TRIAL, 10, 9, 1, 32'hFFFF_FFFE);
    send_request(REQ_TRIAL, 8, 10, 0, 32'd1);
    send_request(REQ_RECOMP, 0, 0, 0, '0);
  endtask

  task automatic test_coupling_limits();
    logic [COUP_W-1:0] code;
    int k;
    for (k = 0; k < 7; k++) begin
      case (k)
        0: code = 5'h10;
        1: code = 5'h17;
        2: code = 5'h09;
        3: code = 5'h0F;
        4: code = 5'h18;
        5: code = 5'h08;
        default: code = 5'h00;
      endcase
      wait_for_results();
      write_register(CFG_COUPLING, {27'($urandom()), code});
      send_request(REQ_TRIAL, 2, 2, 0, '1);
    end
    wait_for_results();
    write_register(CFG_UNUSED, $urandom());
    send_request(REQ_NONE, 2, 2, 0, '0);
  endtask

  task automatic test_random_traffic();
    logic [COUP_W-1:0] code;
    logic [THR_W-1:0] small_v, large_v;
    int phase, n;
    for (phase = 0; phase < 7; phase++) begin
      wait_for_results();
      small_v = $urandom();
      large_v = $urandom();
      sender_pauses = 1'b1;
      sink_stalls = 1'b1;
      case (phase)
        0: begin
          code = 5'h1F;
          small_v = 32'h8000_0000;
          large_v = 32'h2000_0000;
        end
        1: begin
          code = 5'h18;
          small_v = '0;
          large_v = '0;
          sender_pauses = 1'b0;
          sink_stalls = 1'b0;
        end
        2: begin
          code = 5'h08;
          small_v = '1;
          large_v = '1;
        end
        3: code = 5'h00;
        4: begin
          code = 5'h03;
          sink_stalls = 1'b0;
        end
        5: begin
          code = 5'h1B;
          sender_pauses = 1'b0;
        end
        default: code = COUP_W'($urandom());
      endcase
      write_register(CFG_COUPLING, {27'($urandom()), code});
      write_register(CFG_ACC_SMALL, small_v);
      write_register(CFG_ACC_LARGE, large_v);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end
  endtask

  task automatic test_stale_energy();
    int n;
    wait_for_results();
    sender_pauses = 1'b1;
    sink_stalls = 1'b1;
    write_register(CFG_COUPLING, 32'hFFFF_FFF8);
    write_register(CFG_ACC_SMALL, '0);
    write_register(CFG_ACC_LARGE, '0);
    for (n = 0; n < STALE_ITEMS; n++)
      send_request(REQ_TRIAL, 4'($urandom()), 4'($urandom()), 1'($urandom()), random_fraction());
    send_request(REQ_RECOMP, 0, 0, 0, '0);
    wait_for_results();
    // keep the old total: trials now run against a stale energy
    write_register(CFG_COUPLING, 32'd8);
    for (n = 0; n < STALE_ITEMS; n++)
      send_request(REQ_TRIAL, 4'($urandom()), 4'($urandom()), 1'($urandom()), random_fraction());
    send_request(REQ_RECOMP, 0, 0, 0, '0);
  endtask

  task automatic test_output_backpressure();
    int n;
    wait_for_results();
    sender_pauses = 1'b0;
    sink_stalls = 1'b0;
    hold_off_cycles = 300;
    for (n = 0; n < 40; n++) send_random_request();
    wait_for_results();
  endtask

  initial begin : result_sink
    int span;
    forever begin
      if (hold_off_cycles != 0) begin
        span = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 1) == 0) begin
        span = idle_length();
        out_ready <= 1'b0;
      end else begin
        span = sink_stalls ? $urandom_range(1, 6) : 1;
        out_ready <= 1'b1;
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    lattice_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no pending request, energy %0d", $time,
                 total_energy_out);
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", int'(want.accepted), int'(accepted));
        check_field("delta_energy", int'($signed(want.delta)), int'(delta_energy));
        check_field("total_energy_out", int'($signed(want.energy)), int'(total_energy_out));
        check_field("magnetization_out", int'($signed(want.magnet)), int'(magnetization_out));
        check_field("site_spin", int'(want.spin), int'(site_spin));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_NONE;
    x_pos      <= '0;
    y_pos      <= '0;
    spin_value <= 1'b0;
    rand_u     <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_COUPLING;
    cfg_data   <= '0;
    lattice = '1;
    bond_strength = int'(COUP_RST);
    small_threshold = '0;
    large_threshold = '0;
    lattice_energy = 2 * CELLS * bond_strength;
    lattice_magnet = CELLS;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_requests();
    test_coupling_limits();
    test_random_traffic();
    test_stale_energy();
    test_output_backpressure();
    wait_for_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
